// ===== hdl/cts_pkg.sv =====
// shared types, constants and lookup functions for the c token scanner
package cts_pkg;

    localparam int MAX_IDENT = 32;
    localparam int POS_BITS  = 24;
    localparam int PREFIX_N  = 8;

    localparam logic [4:0] KIND_NUM     = 5'd0;
    localparam logic [4:0] KIND_IDENT   = 5'd1;
    localparam logic [4:0] KIND_KEYWORD = 5'd2;
    localparam logic [4:0] KIND_SEMI    = 5'd25;
    localparam logic [4:0] KIND_BAD     = 5'd26;
    localparam logic [4:0] KIND_NONE    = 5'd0;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_NUM   = 2'd1,
        ST_IDENT = 2'd2,
        ST_OP    = 2'd3
    } scan_state_t;

    typedef struct packed {
        logic [4:0]          kind;
        logic [POS_BITS-1:0] index;
        logic [POS_BITS-1:0] start;
        logic [5:0]          length;
        logic [63:0]         value;
        logic [4:0]          kw;
        logic [7:0]          bad;
        logic                ovf;
        logic                last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
            || (c == "_") || (c == "$");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] p);
        logic [4:0] k;
        case (p)
            "+":     k = 5'd3;
            "-":     k = 5'd6;
            "*":     k = 5'd9;
            "/":     k = 5'd11;
            "%":     k = 5'd13;
            "=":     k = 5'd15;
            "!":     k = 5'd17;
            "&":     k = 5'd19;
            "|":     k = 5'd22;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [4:0] base;
        logic       doubles;
        logic [4:0] k;
        base    = single_kind(p);
        doubles = (p == "+") || (p == "-") || (p == "&") || (p == "|");
        k       = KIND_NONE;
        if (base != KIND_NONE) begin
            if (c == "=") begin
                k = doubles ? base + 5'd2 : base + 5'd1;
            end else if ((c == p) && doubles) begin
                k = base + 5'd1;
            end
        end
        return k;
    endfunction

    // keyword text, first character in the top byte, zero padded
    function automatic logic [63:0] kw_text(input logic [4:0] i);
        logic [63:0] t;
        logic [3:0]  n;
        case (i)
            5'd0:    begin t = 64'("auto");     n = 4'd4; end
            5'd1:    begin t = 64'("break");    n = 4'd5; end
            5'd2:    begin t = 64'("case");     n = 4'd4; end
            5'd3:    begin t = 64'("char");     n = 4'd4; end
            5'd4:    begin t = 64'("const");    n = 4'd5; end
            5'd5:    begin t = 64'("continue"); n = 4'd8; end
            5'd6:    begin t = 64'("default");  n = 4'd7; end
            5'd7:    begin t = 64'("do");       n = 4'd2; end
            5'd8:    begin t = 64'("double");   n = 4'd6; end
            5'd9:    begin t = 64'("else");     n = 4'd4; end
            5'd10:   begin t = 64'("enum");     n = 4'd4; end
            5'd11:   begin t = 64'("extern");   n = 4'd6; end
            5'd12:   begin t = 64'("float");    n = 4'd5; end
            5'd13:   begin t = 64'("for");      n = 4'd3; end
            5'd14:   begin t = 64'("goto");     n = 4'd4; end
            5'd15:   begin t = 64'("if");       n = 4'd2; end
            5'd16:   begin t = 64'("int");      n = 4'd3; end
            5'd17:   begin t = 64'("long");     n = 4'd4; end
            5'd18:   begin t = 64'("register"); n = 4'd8; end
            5'd19:   begin t = 64'("return");   n = 4'd6; end
            5'd20:   begin t = 64'("short");    n = 4'd5; end
            5'd21:   begin t = 64'("signed");   n = 4'd6; end
            5'd22:   begin t = 64'("sizeof");   n = 4'd6; end
            5'd23:   begin t = 64'("static");   n = 4'd6; end
            5'd24:   begin t = 64'("struct");   n = 4'd6; end
            5'd25:   begin t = 64'("switch");   n = 4'd6; end
            5'd26:   begin t = 64'("typedef");  n = 4'd7; end
            5'd27:   begin t = 64'("union");    n = 4'd5; end
            5'd28:   begin t = 64'("unsigned"); n = 4'd8; end
            5'd29:   begin t = 64'("void");     n = 4'd4; end
            5'd30:   begin t = 64'("volatile"); n = 4'd8; end
            default: begin t = 64'("while");    n = 4'd5; end
        endcase
        return t << (7'(4'd8 - n) * 7'd8);
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] i);
        logic [63:0] t;
        logic [3:0]  n;
        t = kw_text(i);
        n = 4'd0;
        for (int k = 0; k < PREFIX_N; k++) begin
            if (t[63-8*k -: 8] != 8'd0) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/cts_core.sv =====
// scanner state registers and the one-character step producing up to two tokens
module cts_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      in_char,
    input  logic            end_of_input,
    output cts_pkg::token_t tok0,
    output cts_pkg::token_t tok1,
    output logic [1:0]      tok_count
);
    import cts_pkg::*;

    scan_state_t         st_reg, st_next;
    logic [7:0]          pop_reg, pop_next;
    logic [63:0]         acc_reg, acc_next;
    logic [7:0]          prefix_reg [PREFIX_N], prefix_next [PREFIX_N];
    logic [5:0]          len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] tcnt_reg, tcnt_next;
    logic [POS_BITS-1:0] ccnt_reg, ccnt_next;

    function automatic token_t pend_tok(
        input scan_state_t         st,
        input logic [7:0]          pop,
        input logic [63:0]         acc,
        input logic [63:0]         pv,
        input logic [5:0]          len,
        input logic                ovf,
        input logic [POS_BITS-1:0] start
    );
        token_t t;
        t       = '0;
        t.start = start;
        case (st)
            ST_NUM:
            begin
                t.kind   = KIND_NUM;
                t.length = len;
                t.value  = acc;
                t.ovf    = ovf;
            end
            ST_IDENT:
            begin
                t.kind   = KIND_IDENT;
                t.length = len;
                t.ovf    = ovf;
                if ((len <= 6'd8) && !ovf) begin
                    for (int i = 31; i >= 0; i--) begin
                        if ((6'(kw_len(5'(i))) == len) && (kw_text(5'(i)) == pv)) begin
                            t.kind = KIND_KEYWORD;
                            t.kw   = 5'(i);
                        end
                    end
                end
            end
            ST_OP:
            begin
                t.kind   = single_kind(pop);
                t.length = 6'd1;
            end
            default:
            begin
                t = '0;
            end
        endcase
        return t;
    endfunction

    logic [67:0]  prod;
    logic [63:0]  pv_cur, pv_new;
    logic [4:0]   pk;
    logic         consumed;
    logic         e1, e2, e3;
    token_t       t1, t2, t3;
    token_t       s0, s1;
    logic [7:0]   dval;

    always_comb
    begin
        st_next     = st_reg;
        pop_next    = pop_reg;
        acc_next    = acc_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        start_next  = start_reg;
        consumed    = 1'b0;
        e1          = 1'b0;
        e2          = 1'b0;
        t2          = '0;
        dval        = in_char - 8'd48;
        prod        = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + 68'(dval);
        pk          = pair_kind(pop_reg, in_char);

        for (int k = 0; k < PREFIX_N; k++) begin
            pv_cur[63-8*k -: 8] = prefix_reg[k];
        end
        t1 = pend_tok(st_reg, pop_reg, acc_reg, pv_cur, len_reg, ovf_reg, start_reg);

        case (st_reg)
            ST_OP:
            begin
                e1 = 1'b1;
                st_next = ST_IDLE;
                if (pk != KIND_NONE) begin
                    t1.kind   = pk;
                    t1.length = 6'd2;
                    consumed  = 1'b1;
                end
            end
            ST_NUM:
            begin
                if (is_digit(in_char)) begin
                    consumed = 1'b1;
                    if (prod[67:64] != 4'd0) begin
                        acc_next = '1;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod[63:0];
                    end
                    if (len_reg != 6'd63) begin
                        len_next = len_reg + 6'd1;
                    end
                end else begin
                    e1 = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_IDENT:
            begin
                if (is_ident_char(in_char)) begin
                    consumed = 1'b1;
                    if (len_reg < 6'd8) begin
                        prefix_next[len_reg[2:0]] = in_char;
                    end
                    if (len_reg >= 6'(MAX_IDENT)) begin
                        ovf_next = 1'b1;
                    end
                    if (len_reg != 6'd63) begin
                        len_next = len_reg + 6'd1;
                    end
                end else begin
                    e1 = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                e1 = 1'b0;
            end
        endcase

        if (!consumed && !is_space(in_char)) begin
            if (is_digit(in_char) || is_ident_char(in_char) ||
                (single_kind(in_char) != KIND_NONE)) begin
                start_next = ccnt_reg;
                acc_next   = '0;
                len_next   = 6'd0;
                ovf_next   = 1'b0;
                for (int k = 0; k < PREFIX_N; k++) begin
                    prefix_next[k] = 8'd0;
                end
                if (is_digit(in_char)) begin
                    st_next  = ST_NUM;
                    acc_next = 64'(dval);
                    len_next = 6'd1;
                end else if (is_ident_char(in_char)) begin
                    st_next        = ST_IDENT;
                    prefix_next[0] = in_char;
                    len_next       = 6'd1;
                end else begin
                    st_next  = ST_OP;
                    pop_next = in_char;
                end
            end else begin
                e2        = 1'b1;
                t2.start  = ccnt_reg;
                t2.length = 6'd1;
                if (in_char == ";") begin
                    t2.kind = KIND_SEMI;
                end else begin
                    t2.kind = KIND_BAD;
                    t2.bad  = in_char;
                end
            end
        end

        for (int k = 0; k < PREFIX_N; k++) begin
            pv_new[63-8*k -: 8] = prefix_next[k];
        end
        t3 = pend_tok(st_next, pop_next, acc_next, pv_new, len_next, ovf_next, start_next);
        e3 = end_of_input && (st_next != ST_IDLE);
        if (end_of_input) begin
            st_next = ST_IDLE;
        end

        s0 = e1 ? t1 : (e2 ? t2 : t3);
        s1 = (e1 && e2) ? t2 : t3;
        tok_count = 2'(e1) + 2'(e2) + 2'(e3);
        if (tok_count > 2'd2) begin
            tok_count = 2'd2;
        end
        s0.index = tcnt_reg;
        s1.index = tcnt_reg + POS_BITS'(1);
        s0.last  = (tok_count == 2'd1);
        s1.last  = 1'b1;
        tok0     = s0;
        tok1     = s1;

        tcnt_next = tcnt_reg + POS_BITS'(tok_count);
        ccnt_next = ccnt_reg + POS_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg    <= ST_IDLE;
            pop_reg   <= 8'd0;
            acc_reg   <= '0;
            len_reg   <= 6'd0;
            ovf_reg   <= 1'b0;
            start_reg <= '0;
            tcnt_reg  <= '0;
            ccnt_reg  <= '0;
            for (int k = 0; k < PREFIX_N; k++) begin
                prefix_reg[k] <= 8'd0;
            end
        end else if (step) begin
            st_reg     <= st_next;
            pop_reg    <= pop_next;
            acc_reg    <= acc_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            start_reg  <= start_next;
            tcnt_reg   <= tcnt_next;
            ccnt_reg   <= ccnt_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ===== hdl/cts_fifo.sv =====
// four-entry token queue: takes up to two tokens, gives one per cycle on pop when not empty
module cts_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push_count,
    input  cts_pkg::token_t push0,
    input  cts_pkg::token_t push1,
    input  logic            pop,
    output logic            has_room,
    output logic            not_empty,
    output cts_pkg::token_t head
);
    import cts_pkg::*;

    token_t     mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    assign not_empty = (cnt_reg != 3'd0);
    assign has_room  = (cnt_reg <= 3'd2);
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + push_count;
        rd_next  = rd_reg + 2'(pop && not_empty);
        cnt_next = cnt_reg + 3'(push_count) - 3'(pop && not_empty);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            mem_reg[wr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/c_token_scanner.sv =====
// top level of the c token scanner: input register, scan step and token queue
//
// channel  | handshake            | payload
// input    | in_valid / in_ready  | in_char, end_of_input
// output   | out_valid / out_ready| token_kind .. last_in_run
//
// one character per cycle unless stalled; every token is registered in the queue
// a character waits in the input register until the queue has room for two tokens
// reset clears scan state and counters; the queue starts empty
// a stalled output holds tokens in the queue and then the input register
module c_token_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [23:0] token_index,
    output logic [23:0] start_offset,
    output logic [5:0]  token_length,
    output logic [63:0] number_value,
    output logic [4:0]  keyword_index,
    output logic [7:0]  bad_char,
    output logic        overflow,
    output logic        last_in_run
);
    import cts_pkg::*;

    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] char_reg;
    logic       eoi_reg;
    logic       step;
    logic       room;
    logic [1:0] n_tok;
    token_t     tok0, tok1, head;

    assign step     = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || step;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready) begin
            hold_valid_next = 1'b1;
        end else if (step) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= in_char;
            eoi_reg  <= end_of_input;
        end
    end

    cts_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .in_char      (char_reg),
        .end_of_input (eoi_reg),
        .tok0         (tok0),
        .tok1         (tok1),
        .tok_count    (n_tok)
    );

    cts_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (step ? n_tok : 2'd0),
        .push0      (tok0),
        .push1      (tok1),
        .pop        (out_ready),
        .has_room   (room),
        .not_empty  (out_valid),
        .head       (head)
    );

    assign token_kind    = head.kind;
    assign token_index   = head.index;
    assign start_offset  = head.start;
    assign token_length  = head.length;
    assign number_value  = head.value;
    assign keyword_index = head.kw;
    assign bad_char      = head.bad;
    assign overflow      = head.ovf;
    assign last_in_run   = head.last;

endmodule

// ===== test/c_token_scanner_checker.sv =====
// token predictor and checker for the c token scanner
`timescale 1ns / 1ps

module c_token_scanner_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        end_of_input,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  token_kind,
    input  logic [23:0] token_index,
    input  logic [23:0] start_offset,
    input  logic [5:0]  token_length,
    input  logic [63:0] number_value,
    input  logic [4:0]  keyword_index,
    input  logic [7:0]  bad_char,
    input  logic        overflow,
    input  logic        last_in_run,
    output int          fail_count,
    output int          pending_tokens
);
    import cts_pkg::*;

    typedef struct {
        logic [4:0]  kind;
        logic [23:0] index;
        logic [23:0] start;
        logic [5:0]  length;
        logic [63:0] value;
        logic [4:0]  kw;
        logic [7:0]  bad;
        logic        ovf;
        logic        last;
    } tok_t;

    localparam logic [4:0] OP_PLUS  = 5'd3;
    localparam logic [4:0] OP_MINUS = 5'd6;
    localparam logic [4:0] OP_STAR  = 5'd9;
    localparam logic [4:0] OP_SLASH = 5'd11;
    localparam logic [4:0] OP_PCT   = 5'd13;
    localparam logic [4:0] OP_EQ    = 5'd15;
    localparam logic [4:0] OP_BANG  = 5'd17;
    localparam logic [4:0] OP_AMP   = 5'd19;
    localparam logic [4:0] OP_BAR   = 5'd22;

    string keywords[32] = '{"auto", "break", "case", "char", "const", "continue",
        "default", "do", "double", "else", "enum", "extern", "float", "for", "goto",
        "if", "int", "long", "register", "return", "short", "signed", "sizeof",
        "static", "struct", "switch", "typedef", "union", "unsigned", "void",
        "volatile", "while"};

    tok_t        expected_tokens[$];
    scan_state_t lex_state;
    logic [7:0]  op_char;
    logic [63:0] acc;
    logic [7:0]  prefix[8];
    int          len;
    logic        ovf_seen;
    logic [23:0] tok_start;
    logic [23:0] tok_count;
    logic [23:0] char_count;
    tok_t        step_out[$];

    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_c(logic [7:0] c);
        return digit_c(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == "_" || c == "$";
    endfunction

    function automatic logic [4:0] op_kind(logic [7:0] p);
        case (p)
            "+": return OP_PLUS;
            "-": return OP_MINUS;
            "*": return OP_STAR;
            "/": return OP_SLASH;
            "%": return OP_PCT;
            "=": return OP_EQ;
            "!": return OP_BANG;
            "&": return OP_AMP;
            "|": return OP_BAR;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic [4:0] op_pair(logic [7:0] p, logic [7:0] c);
        logic [4:0] b;
        bit dbl;
        b = op_kind(p);
        dbl = p == "+" || p == "-" || p == "&" || p == "|";
        if (b == KIND_NONE) return KIND_NONE;
        if (c == "=") return dbl ? b + 5'd2 : b + 5'd1;
        if (c == p && dbl) return b + 5'd1;
        return KIND_NONE;
    endfunction

    task automatic push_token(logic [4:0] k, logic [23:0] s, int l, logic [63:0] v,
                              logic [4:0] kw, logic [7:0] b, logic o);
        tok_t t;
        t.kind = k;
        t.index = tok_count;
        t.start = s;
        t.length = l > 63 ? 6'd63 : 6'(l);
        t.value = v;
        t.kw = kw;
        t.bad = b;
        t.ovf = o;
        t.last = 1'b0;
        tok_count = tok_count + 24'd1;
        step_out.push_back(t);
    endtask

    task automatic flush_pending();
        logic [4:0] k;
        logic [4:0] kw;
        bit hit;
        if (lex_state == ST_NUM)
            push_token(KIND_NUM, tok_start, len, acc, 5'd0, 8'd0, ovf_seen);
        else if (lex_state == ST_IDENT) begin
            k = KIND_IDENT;
            kw = 5'd0;
            if (len <= 8 && !ovf_seen)
                for (int i = 0; i < 32; i++) begin
                    hit = keywords[i].len() == len;
                    for (int j = 0; j < len && hit; j++)
                        if (prefix[j] != keywords[i][j]) hit = 0;
                    if (hit && k == KIND_IDENT) begin
                        k = KIND_KEYWORD;
                        kw = 5'(i);
                    end
                end
            push_token(k, tok_start, len, 64'd0, kw, 8'd0, ovf_seen);
        end else if (lex_state == ST_OP)
            push_token(op_kind(op_char), tok_start, 1, 64'd0, 5'd0, 8'd0, 1'b0);
        lex_state = ST_IDLE;
    endtask

    task automatic start_token(scan_state_t s, logic [23:0] p);
        lex_state = s;
        tok_start = p;
        acc = 64'd0;
        len = 0;
        ovf_seen = 1'b0;
        foreach (prefix[i]) prefix[i] = 8'd0;
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - "0");
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) begin
            acc = 64'hFFFF_FFFF_FFFF_FFFF;
            ovf_seen = 1;
        end else
            acc = acc * 10 + d;
        if (len < 63) len++;
    endtask

    task automatic add_word_char(logic [7:0] c);
        if (len < 8) prefix[len] = c;
        if (len >= MAX_IDENT) ovf_seen = 1;
        if (len < 63) len++;
    endtask

    task automatic scan_char(logic [7:0] c, logic eoi);
        bit used;
        logic [4:0] k;
        used = 0;
        step_out.delete();
        if (lex_state == ST_OP) begin
            k = op_pair(op_char, c);
            if (k != KIND_NONE) begin
                push_token(k, tok_start, 2, 64'd0, 5'd0, 8'd0, 1'b0);
                lex_state = ST_IDLE;
                used = 1;
            end else flush_pending();
        end else if (lex_state == ST_NUM) begin
            if (digit_c(c)) begin add_digit(c); used = 1; end
            else flush_pending();
        end else if (lex_state == ST_IDENT) begin
            if (word_c(c)) begin add_word_char(c); used = 1; end
            else flush_pending();
        end
        if (!used) begin
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            end else if (digit_c(c)) begin
                start_token(ST_NUM, char_count);
                add_digit(c);
            end else if (word_c(c)) begin
                start_token(ST_IDENT, char_count);
                add_word_char(c);
            end else if (op_kind(c) != KIND_NONE) begin
                start_token(ST_OP, char_count);
                op_char = c;
            end else if (c == ";")
                push_token(KIND_SEMI, char_count, 1, 64'd0, 5'd0, 8'd0, 1'b0);
            else
                push_token(KIND_BAD, char_count, 1, 64'd0, 5'd0, c, 1'b0);
        end
        if (eoi) flush_pending();
        char_count = char_count + 24'd1;
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        lex_state = ST_IDLE;
        op_char = 8'd0;
        acc = 64'd0;
        len = 0;
        ovf_seen = 1'b0;
        tok_start = 24'd0;
        tok_count = 24'd0;
        char_count = 24'd0;
        foreach (prefix[i]) prefix[i] = 8'd0;
    end

    always @(posedge clk)
    begin
        tok_t e;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_tokens.size() == 0)
                    report("unexpected token", 64'(token_kind), 64'd0);
                else begin
                    e = expected_tokens.pop_front();
                    if (token_kind !== e.kind)
                        report("kind", 64'(token_kind), 64'(e.kind));
                    if (token_index !== e.index)
                        report("index", 64'(token_index), 64'(e.index));
                    if (start_offset !== e.start)
                        report("start", 64'(start_offset), 64'(e.start));
                    if (token_length !== e.length)
                        report("length", 64'(token_length), 64'(e.length));
                    if (number_value !== e.value) report("value", number_value, e.value);
                    if (keyword_index !== e.kw)
                        report("keyword", 64'(keyword_index), 64'(e.kw));
                    if (bad_char !== e.bad) report("bad char", 64'(bad_char), 64'(e.bad));
                    if (overflow !== e.ovf) report("overflow", 64'(overflow), 64'(e.ovf));
                    if (last_in_run !== e.last)
                        report("last", 64'(last_in_run), 64'(e.last));
                end
            end
            if (in_valid && in_ready)
                scan_char(in_char, end_of_input);
        end
        pending_tokens = expected_tokens.size();
    end

endmodule

// ===== test/tb_c_token_scanner.sv =====
// stimulus and verdict for the c token scanner
`timescale 1ns / 1ps

module tb_c_token_scanner;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [7:0]  in_char = 0;
    logic        end_of_input = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [4:0]  token_kind;
    logic [23:0] token_index;
    logic [23:0] start_offset;
    logic [5:0]  token_length;
    logic [63:0] number_value;
    logic [4:0]  keyword_index;
    logic [7:0]  bad_char;
    logic        overflow;
    logic        last_in_run;
    int          fail_count;
    int          pending_tokens;
    bit          quiet_phase = 0;
    bit          hold_output = 0;
    int          n_sent = 0;

    c_token_scanner dut (.*);

    c_token_scanner_checker checker_i (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // leaves valid high after acceptance; the caller or the next gap drops it
    task automatic send_char(logic [7:0] c, logic eoi = 0);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_char <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s, logic eoi = 0);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eoi && i == s.len() - 1);
    endtask

    task automatic send_random_piece();
        int r;
        string frags[12] = '{"while", "volatile", "auto", "x_1$", "+=", "&&", "||",
            "!=", "--", "==", "18446744073709551616", "a;b"};
        r = $urandom_range(0, 9);
        if (r < 4) send_text(frags[$urandom_range(0, 11)]);
        else if (r < 6)
            repeat ($urandom_range(1, 20)) send_char(8'($urandom_range(48, 57)));
        else if (r < 8)
            repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(97, 122)));
        else
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 2) == 0) send_char(" ");
    endtask

    always
    begin
        @(negedge clk);
        if (hold_output) out_ready <= 0;
        else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            out_ready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end else out_ready <= 1;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1;
        send_text("auto while volatile whilex if1 ");
        send_text("0 18446744073709551615 18446744073709551616 12ab ");
        send_text("+ ++ += - -- -= * *= / /= % %= = == ! != & && &= | || |= ;");
        send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ_$9 +");
        send_char(8'h00);
        send_char(8'hFF);
        send_char("@");
        send_text("\t\n\v\f\r+-");
        send_char("7", 1);
        send_char("=", 1);
        fork
            begin
                hold_output = 1;
                repeat (60) @(negedge clk);
                hold_output = 0;
            end
            begin
                repeat (15) send_char(8'($urandom_range(33, 126)));
                repeat (10) send_char(";");
                in_valid <= 0;
            end
        join
        while (pending_tokens != 0) @(negedge clk);
        while (n_sent < 360) send_random_piece();
        quiet_phase = 1;
        repeat (5) send_random_piece();
        send_char("x", 1);
        in_valid <= 0;
        while (pending_tokens != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_tokens == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
